@@ sv/iafp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iafp_pkg
// shared types and constants of the imu angle frame parser
// ----------------------------------------------------------------------------
package iafp_pkg;

    // frame format codes, code 3 is unused and ignores all bytes
    typedef enum logic [1:0] {
        FMT_A = 2'd0,
        FMT_B = 2'd1,
        FMT_C = 2'd2
    } t_fmt;

    // header and tail bytes
    localparam logic [7:0] HDR_A  = 8'hAA;
    localparam logic [7:0] TAIL_A = 8'h55;
    localparam logic [7:0] HDR_B  = 8'h5A;
    localparam logic [7:0] HDR_C0 = 8'h55;
    localparam logic [7:0] HDR_C1 = 8'h53;

    // word/100 as (word * RECIP_100) >> RECIP_SHIFT, exact for 16-bit words
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int          RECIP_SHIFT = 23;

    // format c: word*180/32768 at 8 fraction bits is (word*45) >> 5
    localparam logic [16:0] MUL_C      = 17'd45;
    localparam int          SHIFT_C    = 5;
    localparam logic [15:0] HALF_TURN  = 16'd32768;
    localparam logic [17:0] FULL_TURN  = 18'd92160;

    // format a/b wrap
    localparam logic [9:0]  DEG_LIMIT  = 10'd180;
    localparam logic [9:0]  DEG_WRAP   = 10'd655;

    typedef struct packed {
        logic mul_en;   // load product stage
        logic out_en;   // load angle stage
    } t_lane_ctl;

endpackage
`default_nettype wire

@@ sv/imu_angle_frame_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_core
// serial imu euler angle frame decoder
// ----------------------------------------------------------------------------
// Takes one received byte per request, one byte per clock cycle while the
// input is not stalled, hunts for the header of the format held in the
// format register and produces one roll/pitch/yaw request per complete
// frame in signed q10.8 degrees (roll negated). The header state machine
// updates its position on every accepted byte. On its way to the output
// a frame result passes the frame register, the constant multiply
// register of the three scaling lanes and the result register.
// Each stage moves on whenever the next one is empty or being emptied, so
// input stalls only when all three stages hold results that the output side
// is not taking. Writing the format register restarts the header hunt; the
// user must write it only while no frame is in flight, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // format register
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_wr_data,
    // byte input
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_rx_byte,
    // angle output
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [17:0]      o_roll_angle,
    output logic signed [17:0]      o_pitch_angle,
    output logic signed [17:0]      o_yaw_angle
);

    logic                 w_accept;
    logic                 w_frm_valid;
    logic [2:0][15:0]     w_words;
    logic                 w_is_c;
    logic                 w_out_ready;
    logic                 w_mul_ready;
    logic                 w_take;
    logic                 r_mul_valid;
    logic                 r_out_valid;
    iafp_pkg::t_lane_ctl  w_ctl;

    // stage readiness, back to front
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_mul_ready = !r_mul_valid || w_out_ready;
    assign w_take      = w_frm_valid && w_mul_ready;

    // input only waits when the frame register cannot drain
    assign o_stall  = w_frm_valid && !w_mul_ready;
    assign w_accept = i_valid && !o_stall;

    iafp_framer u_framer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_byte        (i_rx_byte),
        .i_take        (w_take),
        .o_frm_valid   (w_frm_valid),
        .o_words       (w_words),
        .o_is_c        (w_is_c)
    );

    // payload stages load whenever their valid bit advances
    assign w_ctl.mul_en = w_mul_ready;
    assign w_ctl.out_en = w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mul_ready) begin
                r_mul_valid <= w_frm_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_mul_valid;
            end
        end
    end

    // roll lane negates after wrapping
    iafp_lane u_lane_roll (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_word   (w_words[0]),
        .i_is_c   (w_is_c),
        .i_negate (1'b1),
        .o_angle  (o_roll_angle)
    );

    iafp_lane u_lane_pitch (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_word   (w_words[1]),
        .i_is_c   (w_is_c),
        .i_negate (1'b0),
        .o_angle  (o_pitch_angle)
    );

    iafp_lane u_lane_yaw (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_word   (w_words[2]),
        .i_is_c   (w_is_c),
        .i_negate (1'b0),
        .o_angle  (o_yaw_angle)
    );

    assign o_valid = r_out_valid;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input only stalls while a frame waits in the frame register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_frm_valid && r_mul_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    // a blocked multiply stage keeps its request
    a_mul_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mul_valid && !w_out_ready) |=> r_mul_valid)
        else $error("multiply stage request lost");

    // a frame taken into the multiply stage shows up there next cycle
    a_mul_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_mul_valid)
        else $error("frame request not loaded into multiply stage");

endmodule
`default_nettype wire

@@ sv/iafp_framer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iafp_framer
// header hunt, angle byte capture and frame register
// ----------------------------------------------------------------------------
module iafp_framer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [1:0]       i_cfg_wr_data,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_take,
    output logic                  o_frm_valid,
    output logic [2:0][15:0]      o_words,
    output logic                  o_is_c
);

    iafp_pkg::t_fmt  r_fmt;
    logic [3:0]      r_pos;
    logic [3:0]      n_pos;
    logic [7:0]      r_buf [6];
    logic            w_wr_en;
    logic [2:0]      w_wr_idx;
    logic            w_emit;
    logic [7:0]      w_last;
    logic [2:0][15:0] w_words;
    logic            r_frm_valid;
    logic [2:0][15:0] r_words;
    logic            r_is_c;

    always_comb begin
        n_pos    = r_pos;
        w_wr_en  = 1'b0;
        w_wr_idx = 3'd0;
        w_emit   = 1'b0;
        case (r_fmt)
            iafp_pkg::FMT_A: begin
                if (r_pos == 4'd0) begin
                    if (i_byte == iafp_pkg::HDR_A) n_pos = 4'd1;
                end else if (r_pos inside {[4'd1:4'd6]}) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = 3'(r_pos - 4'd1);
                    n_pos    = r_pos + 4'd1;
                end else begin
                    // tail check, a bad tail drops the frame
                    w_emit = (r_pos == 4'd7) && (i_byte == iafp_pkg::TAIL_A);
                    n_pos  = 4'd0;
                end
            end
            iafp_pkg::FMT_B: begin
                if (r_pos == 4'd0) begin
                    if (i_byte == iafp_pkg::HDR_B) n_pos = 4'd1;
                end else if (r_pos == 4'd1) begin
                    n_pos = (i_byte == iafp_pkg::HDR_B) ? 4'd2 : 4'd0;
                end else if (r_pos inside {[4'd2:4'd3]}) begin
                    n_pos = r_pos + 4'd1;
                end else if (r_pos inside {[4'd4:4'd8]}) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = 3'(r_pos - 4'd4);
                    n_pos    = r_pos + 4'd1;
                end else begin
                    w_emit = (r_pos == 4'd9);
                    n_pos  = 4'd0;
                end
            end
            iafp_pkg::FMT_C: begin
                if (r_pos == 4'd0) begin
                    if (i_byte == iafp_pkg::HDR_C0) n_pos = 4'd1;
                end else if (r_pos == 4'd1) begin
                    // a repeated first header byte restarts the header
                    if (i_byte == iafp_pkg::HDR_C1)      n_pos = 4'd2;
                    else if (i_byte == iafp_pkg::HDR_C0) n_pos = 4'd1;
                    else                                 n_pos = 4'd0;
                end else if (r_pos inside {[4'd2:4'd6]}) begin
                    w_wr_en  = 1'b1;
                    w_wr_idx = 3'(r_pos - 4'd2);
                    n_pos    = r_pos + 4'd1;
                end else begin
                    w_emit = (r_pos == 4'd7);
                    n_pos  = 4'd0;
                end
            end
            default: begin
                n_pos = 4'd0;
            end
        endcase
    end

    // last angle byte is the current byte except in format a
    assign w_last = (r_fmt == iafp_pkg::FMT_A) ? r_buf[5] : i_byte;

    always_comb begin
        if (r_fmt == iafp_pkg::FMT_C) begin
            w_words[0] = {r_buf[1], r_buf[0]};
            w_words[1] = {r_buf[3], r_buf[2]};
            w_words[2] = {w_last,   r_buf[4]};
        end else begin
            w_words[0] = {r_buf[0], r_buf[1]};
            w_words[1] = {r_buf[2], r_buf[3]};
            w_words[2] = {r_buf[4], w_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= iafp_pkg::FMT_A;
            r_pos <= 4'd0;
        end else if (i_cfg_wr_en) begin
            r_fmt <= iafp_pkg::t_fmt'(i_cfg_wr_data);
            r_pos <= 4'd0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_wr_en) begin
            r_buf[w_wr_idx] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (i_accept && w_emit) begin
            r_frm_valid <= 1'b1;
        end else if (i_take) begin
            r_frm_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_emit) begin
            r_words <= w_words;
            r_is_c  <= (r_fmt == iafp_pkg::FMT_C);
        end
    end

    assign o_frm_valid = r_frm_valid;
    assign o_words     = r_words;
    assign o_is_c      = r_is_c;

endmodule
`default_nettype wire

@@ sv/iafp_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iafp_lane
// scales one angle word to q10.8 degrees over two register stages
// ----------------------------------------------------------------------------
module iafp_lane (
    input  wire logic                i_clk,
    input  wire iafp_pkg::t_lane_ctl i_ctl,
    input  wire logic [15:0]         i_word,
    input  wire logic                i_is_c,
    input  wire logic                i_negate,
    output logic signed [17:0]       o_angle
);

    logic [32:0]        w_prod;
    logic [16:0]        w_scaled;
    logic [16:0]        r_scaled;
    logic               r_big;
    logic               r_is_c;
    logic [9:0]         w_deg;
    logic [17:0]        w_val;
    logic [17:0]        n_angle;
    logic signed [17:0] r_angle;

    // one constant multiply: reciprocal of 100 or 45/32
    assign w_prod   = {17'd0, i_word} *
                      {16'd0, (i_is_c ? iafp_pkg::MUL_C : iafp_pkg::RECIP_100)};
    assign w_scaled = i_is_c ? w_prod[iafp_pkg::SHIFT_C +: 17]
                             : {7'd0, w_prod[iafp_pkg::RECIP_SHIFT +: 10]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_scaled <= w_scaled;
            r_big    <= (i_word > iafp_pkg::HALF_TURN);
            r_is_c   <= i_is_c;
        end
    end

    // wrap to signed degrees
    always_comb begin
        w_deg = r_scaled[9:0];
        if (r_scaled[9:0] > iafp_pkg::DEG_LIMIT) begin
            w_deg = r_scaled[9:0] - iafp_pkg::DEG_WRAP;
        end
        if (r_is_c) begin
            w_val = {1'b0, r_scaled} - (r_big ? iafp_pkg::FULL_TURN : 18'd0);
        end else begin
            w_val = {w_deg, 8'd0};
        end
        n_angle = i_negate ? (18'd0 - w_val) : w_val;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule
`default_nettype wire
